>>> rtl/core/rmszc_pkg.sv
// Shared constants and register codes for the RMS level and zero-crossing pitch block.
package rmszc_pkg;

  // Default for the longest block before it is closed without a flag.
  localparam int BLOCK_MAX_DEF = 4096;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int GATE_W    = 15;
  localparam int RATE_W    = 18;
  localparam int RMS_W     = 16;
  localparam int PITCH_W   = 21;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 18;

  // Output word: rms_level, pitch_sixteenths, voiced, then zero fill.
  localparam int OUT_BITS   = RMS_W + PITCH_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Square root works on a 32-bit radicand, two bits per step.
  localparam int SQRT_IN_W = 32;
  localparam int ROOT_W    = 16;
  localparam int SQ_REM_W  = 20;

  // Register reset values.
  localparam logic [GATE_W-1:0] GATE_RESET = 15'd328;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_THRESHOLD = 1'b0,
    REG_SAMPLE_RATE    = 1'b1
  } cfg_reg_t;

endpackage

>>> rtl/core/block_rms_and_zero_cross_pitch.sv
// Top level of the block RMS level and zero-crossing pitch estimator.
// Usage: signed Q1.15 samples arrive as words on the in_ channel, in_tlast
// set on the last sample of a block. A block also closes by itself when it
// reaches BLOCK_MAX samples. For each block one result word leaves on the
// out_ channel: the floored RMS, the pitch in 1/16 Hz and a voiced flag.
// The pitch is zero unless the RMS lies strictly above gate_threshold.
// Registers are written through cfg_wr_en / cfg_addr / cfg_wdata; the user
// must write them only while idle, as the block itself does not enforce it.
// Each word is accepted, then added to the sum before another is taken.
// At block end a sequencer drives one shared compare-subtract unit: a
// restoring divide of the square sum by the count (SUM_W steps, 43 with
// the default BLOCK_MAX), a 16-step square root, a gate state, and, for
// a voiced block, a second SUM_W-step divide for the pitch, then ST_FIN
// loads the output register. in_tready stays low from the accepted last
// word of a block until its result is loaded.
// Reset (rst_n low, synchronous) clears all block state, drops out_tvalid
// and restores the register defaults. A stalled receiver holds the result
// in the output register; the block still takes the next block's samples
// and only waits at the end of that block if the old result is still there.
module block_rms_and_zero_cross_pitch
  import rmszc_pkg::*;
#(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tlast,   // last_in_block
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] rms_level, [36:16] pitch_sixteenths,
                                            // [37] voiced, [39:38] zero
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  // Count holds BLOCK_MAX itself; crossings stay below the count.
  localparam int CNT_W   = $clog2(BLOCK_MAX + 1);
  // Largest square is 2^30, so the sum needs 30 bits above the count.
  localparam int SUM_W   = 30 + CNT_W;
  localparam int PROD_W  = CNT_W + RATE_W;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int UW      = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
  localparam int SQ_SHIFT = SUM_W - SQRT_IN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_RMS,
    ST_SQRT,
    ST_GATE,
    ST_DIV_PITCH,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [GATE_W-1:0]   gate_r;
  logic [RATE_W-1:0]   rate_r;

  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cross_r;
  logic                prev_neg_r;
  logic [31:0]         sq_r;
  logic                end_r;

  logic [SUM_W-1:0]    dq_r;
  logic [UW-1:0]       rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [STEP_W-1:0]   step_r;
  logic [RMS_W-1:0]    rms_r;
  logic                voiced_r;
  logic [PITCH_W-1:0]  pitch_r;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Input side.
  logic                in_acc;
  logic                in_neg;
  logic [SAMPLE_W-1:0] in_mag;
  logic [CNT_W-1:0]    cnt_inc;
  logic                in_end;
  logic [SUM_W-1:0]    sum_add;

  // Shared compare-subtract unit.
  logic                div_mode;
  logic [UW-1:0]       unit_a;
  logic [UW-1:0]       unit_b;
  logic [UW:0]         unit_diff;
  logic                unit_ge;
  logic [UW-1:0]       unit_rem;
  logic [SUM_W-1:0]    quot_nxt;
  logic [ROOT_W-1:0]   root_nxt;
  logic [PROD_W-1:0]   pitch_prod;
  logic                gate_pass;
  logic                out_free;
  logic                out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_neg    = in_tdata[SAMPLE_W-1];
  assign in_mag    = in_neg ? (~in_tdata + SAMPLE_W'(1)) : in_tdata;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign in_end    = in_tlast || (cnt_inc == CNT_W'(BLOCK_MAX));
  assign sum_add   = sum_r + SUM_W'(sq_r);

  // Divide steps bring down one dividend bit; root steps bring down two
  // radicand bits and try {root, 01}.
  assign div_mode = (state_r == ST_DIV_RMS) || (state_r == ST_DIV_PITCH);

  always_comb begin
    if (div_mode) begin
      unit_a = {rem_r[UW-2:0], dq_r[SUM_W-1]};
      unit_b = UW'(cnt_r);
    end else begin
      unit_a = {rem_r[UW-3:0], dq_r[SUM_W-1 -: 2]};
      unit_b = UW'({root_r, 2'b01});
    end
  end

  assign unit_diff  = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge    = !unit_diff[UW];
  assign unit_rem   = unit_ge ? unit_diff[UW-1:0] : unit_a;
  assign quot_nxt   = {dq_r[SUM_W-2:0], unit_ge};
  assign root_nxt   = {root_r[ROOT_W-2:0], unit_ge};
  assign pitch_prod = PROD_W'(cross_r) * PROD_W'(rate_r);
  assign gate_pass  = rms_r > {1'b0, gate_r};
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gate_r      <= GATE_RESET;
      rate_r      <= RATE_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      cross_r     <= '0;
      prev_neg_r  <= 1'b0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_GATE_THRESHOLD: gate_r <= cfg_wdata[GATE_W-1:0];
          REG_SAMPLE_RATE:    rate_r <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end

      // A new result may replace the one taken at this same edge.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sq_r  <= 32'(in_mag) * 32'(in_mag);
            cnt_r <= cnt_inc;
            if (cnt_r != '0 && in_neg != prev_neg_r) begin
              cross_r <= cross_r + CNT_W'(1);
            end
            prev_neg_r <= in_end ? 1'b0 : in_neg;
            end_r      <= in_end;
            state_r    <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (end_r) begin
            sum_r   <= '0;
            dq_r    <= sum_add;
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= ST_DIV_RMS;
          end else begin
            sum_r   <= sum_add;
            state_r <= ST_IDLE;
          end
        end
        ST_DIV_RMS: begin
          if (step_r == STEP_W'(SUM_W - 1)) begin
            dq_r    <= quot_nxt << SQ_SHIFT;
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= ST_SQRT;
          end else begin
            dq_r   <= quot_nxt;
            rem_r  <= unit_rem;
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_SQRT: begin
          dq_r   <= dq_r << 2;
          rem_r  <= unit_rem;
          root_r <= root_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(ROOT_W - 1)) begin
            rms_r   <= root_nxt;
            state_r <= ST_GATE;
          end
        end
        ST_GATE: begin
          voiced_r <= gate_pass;
          if (gate_pass) begin
            dq_r    <= SUM_W'({pitch_prod, 3'b000});
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= ST_DIV_PITCH;
          end else begin
            pitch_r <= '0;
            state_r <= ST_FIN;
          end
        end
        ST_DIV_PITCH: begin
          dq_r   <= quot_nxt;
          rem_r  <= unit_rem;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_W - 1)) begin
            pitch_r <= quot_nxt[PITCH_W-1:0];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Wait here only while an older result still sits unread.
          if (out_load) begin
            out_data_r  <= OUT_DATA_W'({voiced_r, pitch_r, rms_r});
            cnt_r       <= '0;
            cross_r     <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // The block count never runs past the longest allowed block.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BLOCK_MAX))
    else $error("sample count above BLOCK_MAX");

  // Crossings are always fewer than samples, or both are zero.
  a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cross_r == '0) || (cross_r < cnt_r))
    else $error("crossing count not below sample count");

  // An unvoiced result carries a zero pitch.
  a_gated_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[RMS_W + PITCH_W]) |-> (out_tdata[RMS_W +: PITCH_W] == '0))
    else $error("pitch nonzero on an unvoiced result");

  // In the cycle after a word is taken the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the block RMS level and zero-crossing pitch estimator.
module tb;
  import rmszc_pkg::*;

  // The watchdog limit is far above the slowest legal run. That run is about
  // 6100 sample words, each one closing a voiced block, plus receiver stalls
  // and sender gaps.
  localparam int LIMIT       = 4_000_000;
  // Idle cycles after the last result before registers change. This covers
  // the longest end-of-block sequence with margin.
  localparam int SETTLE      = 150;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 250;
  // One block runs past the maximum length, so it closes without a flag.
  // The four words after it then form a short flagged block.
  localparam int LONG_RUN    = BLOCK_MAX_DEF + 4;

  // One result word, unpacked into its three fields.
  typedef struct packed {
    logic [RMS_W-1:0]   rms;
    logic [PITCH_W-1:0] pitch;
    logic               voiced;
  } level_t;

  // One row of the directed table. Where "typed" is set, the row carries the
  // result that its block must produce, worked out by hand. Otherwise the
  // predictor supplies the result.
  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    bit                  last;
    bit                  typed;
    level_t              want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata   = '0;   // [15:0] sample
  logic                  in_tlast   = 1'b0; // last_in_block
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] rms_level, [36:16] pitch_sixteenths,
                                            // [37] voiced, [39:38] zero
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata  = '0;

  // Predictor state: the registers as the bench last wrote them, and the
  // running sums of the block that is still open.
  logic [GATE_W-1:0] gate_lvl = GATE_RESET;
  logic [RATE_W-1:0] rate_hz  = RATE_RESET;
  longint unsigned   sq_acc, n_samples, n_crossings;
  bit                was_negative;

  level_t pending_levels[$];   // results still owed by the block, oldest first
  int     mismatches    = 0;
  int     cycles        = 0;
  int     words_out     = 0;
  int     snd_idle_pct  = 0;
  int     rcv_stall_pct = 0;

  // Directed rows. Every block in the table ends on a flagged word, so the
  // random part starts from an empty block.
  dir_row_t dir_rows [18] = '{
    // A silent block right after reset gives all zeros.
    '{16'sd0,      1'b1, 1'b1, '{16'd0,     21'd0,      1'b0}},
    // A full negative scale word gives an RMS of 32768, the only value that
    // needs bit 15 of rms_level.
    '{16'h8000,    1'b1, 1'b1, '{16'd32768, 21'd0,      1'b1}},
    '{16'sd32767,  1'b1, 1'b1, '{16'd32767, 21'd0,      1'b1}},
    // One crossing in two words gives a quarter of the sample rate, in
    // sixteenths of a hertz.
    '{16'sd32767,  1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'h8000,    1'b1, 1'b1, '{16'd32767, 21'd192000, 1'b1}},
    // The gate compare is strict: an RMS equal to the threshold stays
    // unvoiced, and one step above it is voiced.
    '{16'sd328,    1'b1, 1'b1, '{16'd328,   21'd0,      1'b0}},
    '{16'sd329,    1'b1, 1'b1, '{16'd329,   21'd0,      1'b1}},
    // The previous block ends negative and the next one starts positive.
    // The first word of a block has no predecessor, so the pitch stays zero.
    '{-16'sd20000, 1'b1, 1'b1, '{16'd20000, 21'd0,      1'b1}},
    '{16'sd20000,  1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'sd20000,  1'b1, 1'b1, '{16'd20000, 21'd0,      1'b1}},
    // Zero counts as non-negative, so every step between -1000 and 0 is a
    // crossing.
    '{-16'sd1000,  1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'sd0,      1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{-16'sd1000,  1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'sd0,      1'b1, 1'b0, '{16'd0,     21'd0,      1'b0}},
    // A quiet block with the most crossings: it is gated, so its pitch is 0.
    '{-16'sd1,     1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'sd1,      1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{-16'sd1,     1'b0, 1'b0, '{16'd0,     21'd0,      1'b0}},
    '{16'sd1,      1'b1, 1'b0, '{16'd0,     21'd0,      1'b0}}
  };

  block_rms_and_zero_cross_pitch DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap so that a broken block cannot
  // flood the log. Every mismatch is counted.
  task automatic report_mismatch(input string what);
    if (mismatches < 40)
      $display("mismatch at cycle %0d, result %0d: %s", cycles, words_out, what);
    mismatches++;
  endtask

  // Adds one sample word to the open block. Returns 1 when the word closes the
  // block, either by its flag or by reaching the maximum length. In that case
  // res holds the result word that the block must produce.
  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp, input bit last,
                                     output level_t res);
    int              v;
    bit              neg;
    longint unsigned mag, mean, root, cand;
    v    = int'($signed(smp));
    neg  = (v < 0);
    mag  = longint'(neg ? -v : v);
    res  = '0;
    if (n_samples != 0 && neg != was_negative)
      n_crossings++;
    was_negative = neg;
    sq_acc    += mag * mag;
    n_samples++;
    if (!last && n_samples < BLOCK_MAX_DEF)
      return 1'b0;
    // Floor of the square root of the floored mean, one bit at a time from
    // the top.
    mean = sq_acc / n_samples;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= mean)
        root = cand;
    end
    res.rms    = root[RMS_W-1:0];
    res.voiced = (root > gate_lvl);
    if (res.voiced)
      res.pitch = PITCH_W'((n_crossings * rate_hz * 8) / n_samples);
    sq_acc       = 0;
    n_samples    = 0;
    n_crossings  = 0;
    was_negative = 1'b0;
    return 1'b1;
  endfunction

  // Offers one sample word, with random gaps first if the current phase
  // asks for them, and holds it until the block takes it. in_tready is
  // sampled right after the edge, so it still shows its value at that edge.
  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input bit last,
                           input bit typed, input level_t typed_res);
    level_t res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    if (fold_sample(smp, last, res))
      pending_levels.push_back(typed ? typed_res : res);
  endtask

  // Stops sending until every owed result has come out. Then it waits out
  // the block's own latency, because a word that closes no block may still
  // be in progress inside the block.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges. Write enable stays high
  // across the pair and drops once after it.
  task automatic program_regs(input logic [GATE_W-1:0] gate, input logic [RATE_W-1:0] rate);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_GATE_THRESHOLD;
    cfg_wdata <= CFG_DAT_W'(gate);
    @(posedge clk);
    cfg_addr  <= REG_SAMPLE_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gate_lvl = gate;
    rate_hz  = rate;
  endtask

  // Builds sample i of a random block. Each block has one shape: full-scale
  // noise, small noise near the gate, a square wave, a held value (an extreme,
  // 0 or -1), or a faint hiss of a few LSBs.
  function automatic logic [SAMPLE_W-1:0] make_sample(input int shape, input int i,
                                                      input int amp, input int half);
    int v;
    case (shape)
      0:       v = int'($urandom_range(0, 65535)) - 32768;
      1:       v = int'($urandom_range(0, 1200)) - 600;
      2:       v = ((i / half) % 2 != 0) ? -amp : (amp > 32767 ? 32767 : amp);
      3:       v = amp;
      default: v = int'($urandom_range(0, 8)) - 4;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // The receiver. It stalls at random in the phases that ask for it.
  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) < rcv_stall_pct) ? 1'b0 : 1'b1;

  // Result checker. Each result word taken from the block is compared field
  // by field with the oldest owed result.
  always @(posedge clk) begin
    level_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rms    = out_tdata[RMS_W-1:0];
      got.pitch  = out_tdata[RMS_W+PITCH_W-1:RMS_W];
      got.voiced = out_tdata[RMS_W+PITCH_W];
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result word with none owed (rms %0d, pitch %0d)",
                                  got.rms, got.pitch));
      end else begin
        want = pending_levels.pop_front();
        if (got.rms != want.rms)
          report_mismatch($sformatf("rms_level %0d, want %0d", got.rms, want.rms));
        if (got.pitch != want.pitch)
          report_mismatch($sformatf("pitch_sixteenths %0d, want %0d", got.pitch, want.pitch));
        if (got.voiced != want.voiced)
          report_mismatch($sformatf("voiced %0d, want %0d", got.voiced, want.voiced));
      end
      words_out <= words_out + 1;
    end
  end

  // Main sequence: reset, the directed table with the reset register values,
  // then eight random phases. Each phase starts from an idle block with new
  // register values and its own idling mode. Phases end on a word count, not
  // on a block boundary, so a block may span a register change. The drain
  // between phases is also where the sender holds off until every owed
  // result has arrived.
  initial begin
    int gate, rate, budget, sent, len, shape, amp, half, r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k])
      send_word(dir_rows[k].smp, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      // The settings cover both gate extremes, a zero sample rate, the
      // largest 18-bit rate, and some random values in between.
      case (ph)
        0:       begin gate = 328;   rate = 48000;  end
        1:       begin gate = 0;     rate = 8000;   end
        2:       begin gate = 32767; rate = 192000; end
        3:       begin gate = 0;     rate = 0;      end
        4:       begin gate = 1000;  rate = 262143; end
        5:       begin gate = $urandom_range(0, 32767); rate = $urandom_range(8000, 192000); end
        6:       begin gate = 200;   rate = 44100;  end
        default: begin gate = $urandom_range(0, 32767); rate = $urandom_range(0, 262143); end
      endcase
      program_regs(gate[GATE_W-1:0], rate[RATE_W-1:0]);
      case (ph % 4)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_idle_pct = 45; rcv_stall_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct = 45; end
        default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
      endcase

      budget = (ph == 1) ? PHASE_WORDS + LONG_RUN : PHASE_WORDS;
      sent   = 0;
      while (sent < budget) begin
        // Block lengths are mostly short, so results come often. The single
        // overlong block opens phase 1.
        r = $urandom_range(0, 99);
        if (ph == 1 && sent == 0) begin
          len   = LONG_RUN;
          shape = 0;
        end else begin
          len   = (r < 60) ? $urandom_range(1, 16) :
                  (r < 90) ? $urandom_range(17, 128) : $urandom_range(129, 600);
          shape = $urandom_range(0, 4);
        end
        half = $urandom_range(1, 12);
        if (shape == 3) begin
          case ($urandom_range(0, 3))
            0:       amp = -32768;
            1:       amp = 32767;
            2:       amp = 0;
            default: amp = -1;
          endcase
        end else begin
          amp = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(0, 32767);
        end
        for (int i = 0; i < len && sent < budget; i++) begin
          send_word(make_sample(shape, i, amp, half), i == len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rmszc_pkg.sv
rtl/core/block_rms_and_zero_cross_pitch.sv
bench/tb.sv
